// ===== hdl/ascii85_stream_decoder_defines.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ASCII85_STREAM_DECODER_DEFINES_SVH
`define ASCII85_STREAM_DECODER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define A85_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define A85_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/a85_pkg.sv =====
package a85_pkg;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_GROUP = 2'd1,
      PH_TILDE = 2'd2
   } phase_type;

   localparam logic [1:0] ST_DECODING = 2'd0;
   localparam logic [1:0] ST_END      = 2'd1;
   localparam logic [1:0] ST_CORRUPT  = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_BANG  = 8'd33;
   localparam logic [7:0] CH_GT    = 8'd62;
   localparam logic [7:0] CH_LAST  = 8'd118;
   localparam logic [7:0] CH_Z     = 8'd122;
   localparam logic [7:0] CH_TILDE = 8'd126;

   localparam int GROUP_DIGITS = 5;
   localparam int GROUP_BYTES  = 4;

   typedef struct packed {
      logic [31:0] acc;
      logic [1:0]  pad;
      logic [2:0]  nbytes;
      logic [1:0]  status;
   } cmd_type;

   function automatic logic [19:0] pow85(input logic [1:0] m);
      logic [19:0] r;
      case (m)
         2'd0:    r = 20'd1;
         2'd1:    r = 20'd85;
         2'd2:    r = 20'd7225;
         default: r = 20'd614125;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/a85_front.sv =====
module a85_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  logic [7:0]        req_code_char,
   input  logic              req_source_ends,
   output logic              q_push,
   output a85_pkg::cmd_type  q_entry
);
   import a85_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  fin_ff, fin_in;

   logic        accept;
   logic        live;
   logic        is_space;
   logic        is_digit;
   logic [6:0]  digit;
   logic [31:0] acc_step;

   assign accept   = push && !full;
   assign is_space = req_code_char inside {CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
   assign is_digit = req_code_char inside {[CH_BANG:CH_LAST]};
   assign digit    = 7'(req_code_char - CH_BANG);
   assign acc_step = (acc_ff << 6) + (acc_ff << 4) + (acc_ff << 2) + acc_ff + 32'(digit);
   assign live     = accept && (fin_ff == ST_DECODING) && !req_source_ends && !is_space;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      fin_in   = fin_ff;
      if (accept && fin_ff == ST_DECODING && req_source_ends) begin
         fin_in = ST_CORRUPT;
      end else if (live) begin
         case (phase_ff)
            PH_GROUP: begin
               if (req_code_char == CH_TILDE && cnt_ff > 3'd1) begin
                  phase_in = PH_TILDE;
               end else if (is_digit) begin
                  acc_in = acc_step;
                  if (cnt_ff == 3'(GROUP_DIGITS - 1)) begin
                     cnt_in   = 3'd0;
                     phase_in = PH_START;
                  end else begin
                     cnt_in = cnt_ff + 3'd1;
                  end
               end else begin
                  fin_in = ST_CORRUPT;
               end
            end
            PH_TILDE: begin
               if (req_code_char == CH_GT) begin
                  fin_in = ST_END;
                  cnt_in = 3'd0;
               end else begin
                  fin_in = ST_CORRUPT;
               end
            end
            default: begin
               if (req_code_char == CH_TILDE) begin
                  phase_in = PH_TILDE;
               end else if (req_code_char == CH_Z) begin
                  phase_in = PH_START;
               end else if (is_digit) begin
                  acc_in   = 32'(digit);
                  cnt_in   = 3'd1;
                  phase_in = PH_GROUP;
               end else begin
                  fin_in = ST_CORRUPT;
               end
            end
         endcase
      end
   end

   always_comb begin
      q_push         = accept;
      q_entry.acc    = acc_step;
      q_entry.pad    = 2'd0;
      q_entry.nbytes = 3'd0;
      q_entry.status = fin_in;
      if (live) begin
         case (phase_ff)
            PH_GROUP: begin
               if (!(req_code_char == CH_TILDE && cnt_ff > 3'd1) && is_digit &&
                   cnt_ff == 3'(GROUP_DIGITS - 1)) begin
                  q_entry.nbytes = 3'(GROUP_BYTES);
               end
            end
            PH_TILDE: begin
               if (req_code_char == CH_GT && cnt_ff != 3'd0) begin
                  q_entry.acc    = acc_ff;
                  q_entry.pad    = 2'(3'(GROUP_DIGITS) - cnt_ff);
                  q_entry.nbytes = cnt_ff - 3'd1;
               end
            end
            default: begin
               if (req_code_char == CH_Z) begin
                  q_entry.acc    = 32'd0;
                  q_entry.nbytes = 3'(GROUP_BYTES);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         cnt_ff   <= 3'd0;
         fin_ff   <= ST_DECODING;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

// ===== hdl/a85_queue.sv =====
`include "ascii85_stream_decoder_defines.svh"

module a85_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  a85_pkg::cmd_type  wr_data,
   output logic              full,
   input  logic              rd_en,
   output logic              rd_valid,
   output a85_pkg::cmd_type  rd_data
);
   import a85_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entries_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `A85_ASSERT_SAME(a_q_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `A85_ASSERT_NEXT(a_q_fill, clock, reset, do_wr && !do_rd, rd_valid)

endmodule

// ===== hdl/a85_back.sv =====
`include "ascii85_stream_decoder_defines.svh"

module a85_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  a85_pkg::cmd_type  q_entry,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_has_byte,
   output logic              rsp_last,
   output logic [1:0]        rsp_status
);
   import a85_pkg::*;

   logic        mul_valid_ff, mul_valid_in;
   logic [31:0] mul_prod_ff;
   logic [2:0]  mul_n_ff;
   logic [1:0]  mul_status_ff;

   logic        em_valid_ff, em_valid_in;
   logic [31:0] em_val_ff;
   logic [1:0]  em_idx_ff, em_idx_in;
   logic [2:0]  em_n_ff;
   logic [1:0]  em_status_ff;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_has_ff;
   logic        out_last_ff;
   logic [1:0]  out_status_ff;

   logic        out_take, em_fire, em_last, em_free, mul_take, mul_free;
   logic [7:0]  em_byte;

   assign out_take = !out_valid_ff || pop;
   assign em_last  = (em_n_ff == 3'd0) || ({1'b0, em_idx_ff} == em_n_ff - 3'd1);
   assign em_fire  = em_valid_ff && out_take;
   assign em_free  = !em_valid_ff || (em_fire && em_last);
   assign mul_take = mul_valid_ff && em_free;
   assign mul_free = !mul_valid_ff || em_free;
   assign q_pop    = q_valid && mul_free;

   always_comb begin
      case (em_idx_ff)
         2'd0:    em_byte = em_val_ff[31:24];
         2'd1:    em_byte = em_val_ff[23:16];
         2'd2:    em_byte = em_val_ff[15:8];
         default: em_byte = em_val_ff[7:0];
      endcase
   end

   always_comb begin
      mul_valid_in = mul_valid_ff;
      if (mul_free) begin
         mul_valid_in = q_valid;
      end
      em_valid_in = em_valid_ff;
      em_idx_in   = em_idx_ff;
      if (em_free) begin
         em_valid_in = mul_valid_ff;
         em_idx_in   = 2'd0;
      end else if (em_fire) begin
         em_idx_in = em_idx_ff + 2'd1;
      end
      out_valid_in = out_valid_ff;
      if (out_take) begin
         out_valid_in = em_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         em_valid_ff  <= 1'b0;
         em_idx_ff    <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         em_valid_ff  <= em_valid_in;
         em_idx_ff    <= em_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         mul_prod_ff   <= (q_entry.acc + 32'd1) * {12'd0, pow85(q_entry.pad)};
         mul_n_ff      <= q_entry.nbytes;
         mul_status_ff <= q_entry.status;
      end
      if (mul_take) begin
         em_val_ff    <= mul_prod_ff - 32'd1;
         em_n_ff      <= mul_n_ff;
         em_status_ff <= mul_status_ff;
      end
      if (em_fire) begin
         out_has_ff    <= (em_n_ff != 3'd0);
         out_byte_ff   <= (em_n_ff != 3'd0) ? em_byte : 8'd0;
         out_last_ff   <= em_last;
         out_status_ff <= em_status_ff;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_data_byte = out_byte_ff;
   assign rsp_has_byte  = out_has_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_status    = out_status_ff;

   `A85_ASSERT_SAME(a_empty_word_last, clock, reset, out_valid_ff && !out_has_ff, out_last_ff)
   `A85_ASSERT_SAME(a_em_idx_range, clock, reset, em_valid_ff && em_n_ff != 3'd0,
                    {1'b0, em_idx_ff} < em_n_ff)
   `A85_ASSERT_NEXT(a_mul_to_em, clock, reset, mul_take, em_valid_ff && em_idx_ff == 2'd0)
   `A85_ASSERT_SAME(a_em_bytes_max, clock, reset, em_valid_ff, em_n_ff <= 3'(GROUP_BYTES))

endmodule

// ===== hdl/ascii85_stream_decoder.sv =====
// An item passes the queue, the multiply stage, the byte emitter and the output register.
// Throughput: one character per cycle in while full is low; one word per cycle out while pop
// is held; an item that decodes k bytes gives max(1, k) words; the queue absorbs 'z' bursts.
// Reset (synchronous, active high) returns to group start with status decoding and
// empties the queue and all stages.
module ascii85_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_code_char,
   input  logic       req_source_ends,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_byte,
   output logic       rsp_last,
   output logic [1:0] rsp_status
);
   import a85_pkg::*;

   logic    q_push, q_valid, q_pop;
   cmd_type q_wr_entry, q_rd_entry;

   a85_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_code_char   (req_code_char),
      .req_source_ends (req_source_ends),
      .q_push          (q_push),
      .q_entry         (q_wr_entry)
   );

   a85_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wr_entry),
      .full     (full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rd_entry)
   );

   a85_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_entry       (q_rd_entry),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_data_byte (rsp_data_byte),
      .rsp_has_byte  (rsp_has_byte),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status)
   );

endmodule

// ===== tb/ascii85_decode_checker.sv =====
`timescale 1ns / 100ps
module ascii85_decode_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] req_code_char,
   input  logic       req_source_ends,
   input  logic       empty,
   input  logic       pop,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_has_byte,
   input  logic       rsp_last,
   input  logic [1:0] rsp_status,
   output int         mismatches,
   output int         words_due
);
   import a85_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
      logic [1:0] status;
   } decoded_word_type;

   decoded_word_type decoded_due[$];
   decoded_word_type got_word;
   decoded_word_type due_word;
   logic [7:0]       decoded_bytes[$];

   phase_type     phase;
   logic [2:0]    digit_count;
   logic [6:0]    digit_store[GROUP_DIGITS];
   logic [1:0]    finish_status;

   function void unpack_group();
      logic [31:0] value;
      logic [6:0]  digit;
      value = 32'd0;
      for (int i = 0; i < GROUP_DIGITS; i++) begin
         digit = (i < digit_count) ? digit_store[i] : 7'd84;
         value = value * 32'd85 + 32'(digit);
      end
      for (int i = 0; i + 1 < digit_count && i < GROUP_BYTES; i++)
         decoded_bytes = {decoded_bytes, value[31 - 8 * i -: 8]};
      digit_count = 3'd0;
   endfunction

   function void decode_char(input logic [7:0] ch, input logic ends);
      logic             is_digit;
      decoded_word_type word;
      is_digit = (ch >= CH_BANG) && (ch <= CH_LAST);
      decoded_bytes.delete();
      if (finish_status != ST_DECODING) begin
      end else if (ends) begin
         finish_status = ST_CORRUPT;
      end else if (ch == CH_NUL || ch == CH_TAB || ch == CH_LF || ch == CH_FF ||
                   ch == CH_CR || ch == CH_SPACE) begin
      end else begin
         case (phase)
            PH_GROUP: begin
               if (ch == CH_TILDE && digit_count > 3'd1) begin
                  phase = PH_TILDE;
               end else if (is_digit && digit_count < 3'(GROUP_DIGITS)) begin
                  digit_store[digit_count] = 7'(ch - CH_BANG);
                  digit_count++;
                  if (digit_count == 3'(GROUP_DIGITS)) begin
                     unpack_group();
                     phase = PH_START;
                  end
               end else begin
                  finish_status = ST_CORRUPT;
               end
            end
            PH_TILDE: begin
               if (ch == CH_GT) begin
                  if (digit_count > 3'd0)
                     unpack_group();
                  finish_status = ST_END;
               end else begin
                  finish_status = ST_CORRUPT;
               end
            end
            default: begin
               if (ch == CH_TILDE) begin
                  phase = PH_TILDE;
               end else if (ch == CH_Z) begin
                  for (int i = 0; i < GROUP_BYTES; i++)
                     decoded_bytes = {decoded_bytes, 8'h00};
               end else if (is_digit) begin
                  digit_store[0] = 7'(ch - CH_BANG);
                  digit_count = 3'd1;
                  phase = PH_GROUP;
               end else begin
                  finish_status = ST_CORRUPT;
               end
            end
         endcase
      end
      word.status = finish_status;
      if (decoded_bytes.size() == 0) begin
         word.data_byte = 8'h00;
         word.has_byte = 1'b0;
         word.last = 1'b1;
         decoded_due = {decoded_due, word};
      end else begin
         foreach (decoded_bytes[i]) begin
            word.data_byte = decoded_bytes[i];
            word.has_byte = 1'b1;
            word.last = (i == decoded_bytes.size() - 1);
            decoded_due = {decoded_due, word};
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase = PH_START;
         digit_count = 3'd0;
         finish_status = ST_DECODING;
         decoded_due.delete();
      end else begin
         if (pop && !empty) begin
            got_word.data_byte = rsp_data_byte;
            got_word.has_byte = rsp_has_byte;
            got_word.last = rsp_last;
            got_word.status = rsp_status;
            if (decoded_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected word: byte %h has %b last %b status %0d",
                           rsp_data_byte, rsp_has_byte, rsp_last, rsp_status);
               mismatches++;
            end else begin
               due_word = decoded_due.pop_front();
               if (got_word !== due_word) begin
                  if (mismatches < 10)
                     $display({"word mismatch: expected byte %h has %b last %b status %0d,",
                               " got byte %h has %b last %b status %0d"},
                              due_word.data_byte, due_word.has_byte, due_word.last,
                              due_word.status, rsp_data_byte, rsp_has_byte, rsp_last,
                              rsp_status);
                  mismatches++;
               end
            end
         end
         if (push && !full)
            decode_char(req_code_char, req_source_ends);
      end
      words_due = decoded_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import a85_pkg::*;

   localparam int CHAR_TARGET = 160;
   localparam int CALM_AFTER  = 130;
   localparam int CYCLE_LIMIT = 100000;

   typedef enum int {
      END_MARK,
      END_SOURCE,
      END_ILLEGAL,
      END_Z_IN_GROUP,
      END_LONE_DIGIT,
      END_BAD_TILDE
   } ending_type;

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_code_char;
   logic       req_source_ends;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_data_byte;
   logic       rsp_has_byte;
   logic       rsp_last;
   logic [1:0] rsp_status;
   int         mismatches;
   int         words_due;
   int         chars_sent;
   int         cycle_count;
   int         stall_left;
   logic       calm;
   ending_type ending;
   logic [7:0] ch;

   ascii85_stream_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_code_char   (req_code_char),
      .req_source_ends (req_source_ends),
      .empty           (empty),
      .pop             (pop),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

   ascii85_decode_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_code_char   (req_code_char),
      .req_source_ends (req_source_ends),
      .empty           (empty),
      .pop             (pop),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .mismatches      (mismatches),
      .words_due       (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] pick_blank();
      logic [7:0] blanks[6];
      blanks = '{CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
      return blanks[$urandom_range(0, 5)];
   endfunction

   function automatic logic [7:0] pick_illegal();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while ((c >= CH_BANG && c <= CH_LAST) || c == CH_Z || c == CH_TILDE ||
             c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
             c == CH_CR || c == CH_SPACE);
      return c;
   endfunction

   task automatic send_word(input logic [7:0] c, input logic ends);
      if (!calm && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      push <= 1'b1;
      req_code_char <= c;
      req_source_ends <= ends;
      @(posedge clock);
      while (full) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_digits(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_word(pick_blank(), 1'b0);
         send_word(8'($urandom_range(CH_BANG, CH_LAST)), 1'b0);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], 1'b0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      pop <= 1'b0;
      stall_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      // hold off long enough for the block to fill and stall its input
      repeat (60) @(posedge clock);
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 8);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      chars_sent = 0;
      calm = 1'b0;
      reset <= 1'b1;
      push <= 1'b0;
      req_code_char <= 8'h00;
      req_source_ends <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_word(CH_NUL, 1'b0);
      send_word(CH_TAB, 1'b0);
      send_word(CH_LF, 1'b0);
      send_word(CH_FF, 1'b0);
      send_word(CH_CR, 1'b0);
      send_word(CH_SPACE, 1'b0);
      send_text("!!!!!");
      send_word(CH_Z, 1'b0);
      send_text("s8W-!");
      send_text("vvvvv");
      send_word(CH_Z, 1'b0);
      send_text("uu uuu");

      while (chars_sent < CHAR_TARGET) begin
         calm = (chars_sent >= CALM_AFTER);
         case ($urandom_range(0, 9))
            0, 1:    send_word(CH_Z, 1'b0);
            2:       send_word(pick_blank(), 1'b0);
            3:       send_text("s8W-!");
            default: send_digits(GROUP_DIGITS);
         endcase
      end
      calm = 1'b1;

      ending = ending_type'($urandom_range(0, 5));
      case (ending)
         END_MARK: begin
            send_digits($urandom_range(0, 1) ? $urandom_range(2, 4) : 0);
            send_word(CH_TILDE, 1'b0);
            if ($urandom_range(0, 1))
               send_word(pick_blank(), 1'b0);
            send_word(CH_GT, 1'b0);
         end
         END_SOURCE: begin
            send_digits($urandom_range(0, 4));
            send_word(8'($urandom_range(0, 255)), 1'b1);
         end
         END_ILLEGAL: begin
            send_digits($urandom_range(0, 4));
            send_word(pick_illegal(), 1'b0);
         end
         END_Z_IN_GROUP: begin
            send_digits($urandom_range(1, 4));
            send_word(CH_Z, 1'b0);
         end
         END_LONE_DIGIT: begin
            send_digits(1);
            send_word(CH_TILDE, 1'b0);
         end
         default: begin
            send_digits($urandom_range(0, 1) ? $urandom_range(2, 4) : 0);
            send_word(CH_TILDE, 1'b0);
            do
               ch = 8'($urandom_range(0, 255));
            while (ch == CH_GT || ch == CH_NUL || ch == CH_TAB || ch == CH_LF ||
                   ch == CH_FF || ch == CH_CR || ch == CH_SPACE);
            send_word(ch, 1'b0);
         end
      endcase

      // send more characters after the stream has closed; they decode no bytes
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      for (int i = 0; i < 6; i++)
         send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_word(8'($urandom_range(0, 255)), 1'b1);
      push <= 1'b0;

      @(negedge clock);
      while (words_due != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
